/* sv/encoder_drive_pid_controller_top_macros.svh */
// Assertion macros for the checker module.
`ifndef ENCODER_DRIVE_PID_CONTROLLER_TOP_MACROS_SVH
`define ENCODER_DRIVE_PID_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, masked during reset.
`define EDPC_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("edpc assertion failed");

// Next-cycle implication, masked during reset.
`define EDPC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("edpc assertion failed");

// Next-cycle implication that also holds across reset.
`define EDPC_ASSERT_NEXT_ALWAYS(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("edpc assertion failed");

`endif

/* sv/edpc_pkg.sv */
package edpc_pkg;

  // Block parameters
  localparam int PWM_LOW    = 0;
  localparam int PWM_HIGH   = 255;
  localparam int COUNT_BITS = 16;

  // Field and datapath widths
  localparam int CNT_W  = COUNT_BITS;
  localparam int ERR_W  = CNT_W + 1;
  localparam int DIF_W  = CNT_W + 2;
  localparam int SUM_W  = 32;
  localparam int SPD_W  = 32;
  localparam int FRAC_W = 16;
  localparam int GAIN_W = 24;
  localparam int TGT_W  = 16;
  localparam int PCT_W  = 7;
  localparam int PWM_W  = 8;
  localparam int CFG_W  = 24;
  localparam int IDX_W  = 3;
  localparam int MAG_W  = SPD_W - FRAC_W;

  localparam int OPND_W = (SUM_W > DIF_W) ? SUM_W : DIF_W;
  localparam int TRM_W  = OPND_W + 2;
  localparam int ACC_W  = TRM_W + 1;
  localparam int HI_W   = SPD_W - GAIN_W;
  localparam int CMP_W  = (CNT_W > TGT_W) ? CNT_W : TGT_W;
  localparam int SACC_W = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;
  localparam int CYC_W  = $clog2(GAIN_W);

  // Percent to duty mapping: divide by 100 through a scaled reciprocal
  localparam int PCT_MAX  = 100;
  localparam int DUTY_SH  = 19;
  localparam int DUTY_MUL = (PWM_HIGH - PWM_LOW) * ((2**DUTY_SH + PCT_MAX - 1) / PCT_MAX);

  // Register indexes
  localparam logic [IDX_W-1:0] REG_MODE     = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_TURN_DIR = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_TARGET   = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_BASE     = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_TURN_SPD = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_GAIN_P   = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_GAIN_I   = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_GAIN_D   = IDX_W'(7);

  // Register reset values
  localparam logic [PCT_W-1:0]  RST_BASE     = PCT_W'(90);
  localparam logic [PCT_W-1:0]  RST_TURN_SPD = PCT_W'(100);
  localparam logic [GAIN_W-1:0] RST_GAIN_P   = GAIN_W'(655360);
  localparam logic [GAIN_W-1:0] RST_GAIN_I   = GAIN_W'(328);
  localparam logic [GAIN_W-1:0] RST_GAIN_D   = GAIN_W'(0);

  // Item and mode codes
  localparam logic OP_START      = 1'b0;
  localparam logic OP_TICK       = 1'b1;
  localparam logic MODE_STRAIGHT = 1'b0;
  localparam logic MODE_TURN     = 1'b1;

  // Request into the serial PID unit
  typedef struct packed {
    logic                    start;
    logic signed [ERR_W-1:0] err;
    logic signed [SUM_W-1:0] sum;
    logic signed [DIF_W-1:0] diff;
    logic [PCT_W-1:0]        base;
  } pid_req_t;

  // Response from the serial PID unit
  typedef struct packed {
    logic                    done;
    logic signed [SPD_W-1:0] speed;
  } pid_rsp_t;

  // Clamp an integer percent magnitude to 100 and map it onto the PWM range
  function automatic logic [PWM_W-1:0] pct_duty(input logic [MAG_W-1:0] mag);
    logic [PCT_W-1:0] pct;
    logic [31:0]      prod;
    pct  = (mag > MAG_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : mag[PCT_W-1:0];
    prod = 32'(pct) * 32'(DUTY_MUL);
    return PWM_W'(prod >> DUTY_SH) + PWM_W'(PWM_LOW);
  endfunction

endpackage

/* sv/edpc_pid_serial.sv */
module edpc_pid_serial (
  input  logic                                clk,
  input  logic                                rst,
  input  edpc_pkg::pid_req_t                  req,
  input  logic [edpc_pkg::GAIN_W-1:0]         gain_p,
  input  logic [edpc_pkg::GAIN_W-1:0]         gain_i,
  input  logic [edpc_pkg::GAIN_W-1:0]         gain_d,
  output edpc_pkg::pid_rsp_t                  rsp
);

  logic                                   busy;
  logic                                   done;
  logic [edpc_pkg::CYC_W-1:0]             cnt;
  logic [edpc_pkg::GAIN_W-1:0]            gp;
  logic [edpc_pkg::GAIN_W-1:0]            gi;
  logic [edpc_pkg::GAIN_W-1:0]            gd;
  logic [edpc_pkg::GAIN_W-1:0]            bsh;
  logic signed [edpc_pkg::ERR_W-1:0]      err_q;
  logic signed [edpc_pkg::SUM_W-1:0]      sum_q;
  logic signed [edpc_pkg::DIF_W-1:0]      diff_q;
  logic signed [edpc_pkg::ACC_W-1:0]      acc;
  logic [edpc_pkg::GAIN_W-1:0]            low;

  logic signed [edpc_pkg::ACC_W-1:0]      t_b;
  logic signed [edpc_pkg::ACC_W-1:0]      t_p;
  logic signed [edpc_pkg::ACC_W-1:0]      t_i;
  logic signed [edpc_pkg::ACC_W-1:0]      t_d;
  logic signed [edpc_pkg::ACC_W-1:0]      acc_sum;
  logic [edpc_pkg::ACC_W-edpc_pkg::HI_W:0] hi;
  logic                                   fits;

  // Select this bit's partial products; the base speed enters one bit a cycle
  always_comb begin
    t_b     = $signed(edpc_pkg::ACC_W'(bsh[0]));
    t_p     = gp[0] ? edpc_pkg::ACC_W'(err_q)  : '0;
    t_i     = gi[0] ? edpc_pkg::ACC_W'(sum_q)  : '0;
    t_d     = gd[0] ? edpc_pkg::ACC_W'(diff_q) : '0;
    acc_sum = acc + t_b - t_p - t_i - t_d;
  end

  // Saturate the finished value to 32-bit signed
  always_comb begin
    hi   = acc[edpc_pkg::ACC_W-1:edpc_pkg::HI_W-1];
    fits = (&hi) | (~|hi);
    rsp.done = done;
    if (fits) begin
      rsp.speed = $signed({acc[edpc_pkg::HI_W-1:0], low});
    end else if (acc[edpc_pkg::ACC_W-1]) begin
      rsp.speed = $signed({1'b1, {(edpc_pkg::SPD_W-1){1'b0}}});
    end else begin
      rsp.speed = $signed({1'b0, {(edpc_pkg::SPD_W-1){1'b1}}});
    end
  end

  // Scan the gains LSB first, shifting finished bits out of the accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (req.start) begin
        busy   <= 1'b1;
        done   <= 1'b0;
        cnt    <= '0;
        acc    <= '0;
        gp     <= gain_p;
        gi     <= gain_i;
        gd     <= gain_d;
        bsh    <= edpc_pkg::GAIN_W'({req.base, {edpc_pkg::FRAC_W{1'b0}}});
        err_q  <= req.err;
        sum_q  <= req.sum;
        diff_q <= req.diff;
      end else if (busy) begin
        acc  <= acc_sum >>> 1;
        low  <= {acc_sum[0], low[edpc_pkg::GAIN_W-1:1]};
        gp   <= gp >> 1;
        gi   <= gi >> 1;
        gd   <= gd >> 1;
        bsh  <= bsh >> 1;
        cnt  <= cnt + 1'b1;
        done <= (cnt == edpc_pkg::CYC_W'(edpc_pkg::GAIN_W - 1));
        if (cnt == edpc_pkg::CYC_W'(edpc_pkg::GAIN_W - 1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

/* sv/encoder_drive_pid_controller_top.sv */
// Two-wheel drive controller. Start items (s_tuser low) clear the encoder counts and PID state
// and begin a motion; tick items (s_tuser high) add the encoder pulses in s_tdata. Every item
// returns exactly one result with PWM duty and direction bits for both wheels; m_tlast marks the
// result that ends a motion, when either count reaches target_count, and that result has all
// direction and PWM bits low. Items are handled one at a time. A start item or an idle tick
// goes from acceptance straight to S_EMIT, a turn-mode or stopping tick passes S_EVAL first;
// a straight-mode tick passes S_EVAL and then waits in S_MUL for the PID unit, which scans
// the 24-bit gains one bit per cycle. A finished result sits in the output register, so the
// next item is taken the cycle after it is loaded even while m_tready is low. Configuration
// writes are always ready.
module encoder_drive_pid_controller_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [0] left_pulse, [1] right_pulse
  input  logic                          s_tuser,   // [0] opcode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [7:0] left_pwm, [8] left_forward, [9] left_backward,
  // [17:10] right_pwm, [18] right_forward, [19] right_backward
  output logic [23:0]                   m_tdata,
  output logic                          m_tlast,   // done_res
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [edpc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [edpc_pkg::CFG_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_EMIT
  } state_t;

  state_t state;

  // Configuration registers
  logic                          mode;
  logic                          turn_dir;
  logic [edpc_pkg::TGT_W-1:0]    target_count;
  logic [edpc_pkg::PCT_W-1:0]    cruise_speed;
  logic [edpc_pkg::PCT_W-1:0]    turn_speed;
  logic [edpc_pkg::GAIN_W-1:0]   gain_p;
  logic [edpc_pkg::GAIN_W-1:0]   gain_i;
  logic [edpc_pkg::GAIN_W-1:0]   gain_d;

  // Motion state
  logic [edpc_pkg::CNT_W-1:0]        left_count;
  logic [edpc_pkg::CNT_W-1:0]        right_count;
  logic signed [edpc_pkg::SUM_W-1:0] error_sum;
  logic signed [edpc_pkg::ERR_W-1:0] last_error;
  logic signed [edpc_pkg::SPD_W-1:0] right_speed_now;
  logic                              running;
  logic                              res_stop;
  logic                              res_done;

  logic                                reached;
  logic signed [edpc_pkg::ERR_W-1:0]   err;
  logic signed [edpc_pkg::DIF_W-1:0]   diff;
  logic signed [edpc_pkg::SACC_W-1:0]  sum_wide;
  logic [edpc_pkg::SACC_W-edpc_pkg::SUM_W:0] sum_hi;
  logic signed [edpc_pkg::SUM_W-1:0]   sum_sat;
  edpc_pkg::pid_req_t                  pid_req;
  edpc_pkg::pid_rsp_t                  pid_rsp;

  logic                          turn_nz;
  logic                          l_rev;
  logic                          r_rev;
  logic [edpc_pkg::MAG_W-1:0]    l_mag;
  logic [edpc_pkg::MAG_W-1:0]    r_mag;
  logic [edpc_pkg::SPD_W-1:0]    rsn_abs;
  logic [edpc_pkg::PWM_W-1:0]    l_pwm;
  logic [edpc_pkg::PWM_W-1:0]    r_pwm;
  logic [23:0]                   out_data;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Hold configuration registers, write one per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= 1'b0;
      turn_dir     <= 1'b0;
      target_count <= '0;
      cruise_speed <= edpc_pkg::RST_BASE;
      turn_speed   <= edpc_pkg::RST_TURN_SPD;
      gain_p       <= edpc_pkg::RST_GAIN_P;
      gain_i       <= edpc_pkg::RST_GAIN_I;
      gain_d       <= edpc_pkg::RST_GAIN_D;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        edpc_pkg::REG_MODE:     mode         <= cfg_data[0];
        edpc_pkg::REG_TURN_DIR: turn_dir     <= cfg_data[0];
        edpc_pkg::REG_TARGET:   target_count <= cfg_data[edpc_pkg::TGT_W-1:0];
        edpc_pkg::REG_BASE:     cruise_speed <= cfg_data[edpc_pkg::PCT_W-1:0];
        edpc_pkg::REG_TURN_SPD: turn_speed   <= cfg_data[edpc_pkg::PCT_W-1:0];
        edpc_pkg::REG_GAIN_P:   gain_p       <= cfg_data[edpc_pkg::GAIN_W-1:0];
        edpc_pkg::REG_GAIN_I:   gain_i       <= cfg_data[edpc_pkg::GAIN_W-1:0];
        edpc_pkg::REG_GAIN_D:   gain_d       <= cfg_data[edpc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Compare counts to target and form the error terms
  always_comb begin
    reached  = (edpc_pkg::CMP_W'(left_count)  >= edpc_pkg::CMP_W'(target_count)) ||
               (edpc_pkg::CMP_W'(right_count) >= edpc_pkg::CMP_W'(target_count));
    err      = $signed({1'b0, right_count}) - $signed({1'b0, left_count});
    diff     = edpc_pkg::DIF_W'(err) - edpc_pkg::DIF_W'(last_error);
    sum_wide = edpc_pkg::SACC_W'(error_sum) + edpc_pkg::SACC_W'(err);
    sum_hi   = sum_wide[edpc_pkg::SACC_W-1:edpc_pkg::SUM_W-1];
    if ((&sum_hi) || (~|sum_hi)) begin
      sum_sat = sum_wide[edpc_pkg::SUM_W-1:0];
    end else if (sum_wide[edpc_pkg::SACC_W-1]) begin
      sum_sat = $signed({1'b1, {(edpc_pkg::SUM_W-1){1'b0}}});
    end else begin
      sum_sat = $signed({1'b0, {(edpc_pkg::SUM_W-1){1'b1}}});
    end
  end

  // Launch the PID unit on a running straight-mode tick
  always_comb begin
    pid_req.start = (state == S_EVAL) && !reached && (mode == edpc_pkg::MODE_STRAIGHT);
    pid_req.err   = err;
    pid_req.sum   = sum_sat;
    pid_req.diff  = diff;
    pid_req.base  = cruise_speed;
  end

  edpc_pid_serial u_pid (
    .clk    (clk),
    .rst    (rst),
    .req    (pid_req),
    .gain_p (gain_p),
    .gain_i (gain_i),
    .gain_d (gain_d),
    .rsp    (pid_rsp)
  );

  // Turn wheel speeds into direction bits and duty
  always_comb begin
    turn_nz = (turn_speed != '0);
    rsn_abs = right_speed_now[edpc_pkg::SPD_W-1] ?
              (~right_speed_now + 1'b1) : right_speed_now;
    if (mode == edpc_pkg::MODE_TURN) begin
      l_rev = !turn_dir && turn_nz;
      r_rev = turn_dir && turn_nz;
      l_mag = edpc_pkg::MAG_W'(turn_speed);
      r_mag = edpc_pkg::MAG_W'(turn_speed);
    end else begin
      l_rev = 1'b0;
      r_rev = right_speed_now[edpc_pkg::SPD_W-1];
      l_mag = edpc_pkg::MAG_W'(cruise_speed);
      r_mag = rsn_abs[edpc_pkg::SPD_W-1:edpc_pkg::FRAC_W];
    end
    l_pwm = edpc_pkg::pct_duty(l_mag);
    r_pwm = edpc_pkg::pct_duty(r_mag);
    if (res_stop) begin
      out_data = '0;
    end else begin
      out_data = {4'b0, r_rev, !r_rev, r_pwm, l_rev, !l_rev, l_pwm};
    end
  end

  // Sequence one item and register its result
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_tvalid        <= 1'b0;
      running         <= 1'b0;
      left_count      <= '0;
      right_count     <= '0;
      error_sum       <= '0;
      last_error      <= '0;
      right_speed_now <= '0;
    end else begin
      // Drop a taken result unless a new one loads this cycle
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == edpc_pkg::OP_START) begin
              left_count      <= '0;
              right_count     <= '0;
              error_sum       <= '0;
              last_error      <= '0;
              right_speed_now <= $signed(edpc_pkg::SPD_W'({cruise_speed,
                                                            {edpc_pkg::FRAC_W{1'b0}}}));
              res_stop        <= (target_count == '0);
              res_done        <= (target_count == '0);
              running         <= (target_count != '0);
              state           <= S_EMIT;
            end else if (!running) begin
              res_stop <= 1'b1;
              res_done <= 1'b0;
              state    <= S_EMIT;
            end else begin
              if (s_tdata[0] && (left_count != '1)) begin
                left_count <= left_count + 1'b1;
              end
              if (s_tdata[1] && (right_count != '1)) begin
                right_count <= right_count + 1'b1;
              end
              state <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          if (reached) begin
            running  <= 1'b0;
            res_stop <= 1'b1;
            res_done <= 1'b1;
            state    <= S_EMIT;
          end else if (mode == edpc_pkg::MODE_TURN) begin
            res_stop <= 1'b0;
            res_done <= 1'b0;
            state    <= S_EMIT;
          end else begin
            error_sum  <= sum_sat;
            last_error <= err;
            res_stop   <= 1'b0;
            res_done   <= 1'b0;
            state      <= S_MUL;
          end
        end
        S_MUL: begin
          if (pid_rsp.done) begin
            right_speed_now <= pid_rsp.speed;
            state           <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= out_data;
            m_tlast  <= res_done;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/edpc_checker.sv */
`include "encoder_drive_pid_controller_top_macros.svh"

module edpc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [23:0]                   m_tdata,
  input logic                          m_tlast
);

  // Reset drops any pending result
  `EDPC_ASSERT_NEXT_ALWAYS(a_rst_clears_out, rst, !m_tvalid)

  // One item at a time: no transaction in the cycle after an accepted one
  `EDPC_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

  // A stalled result stays valid
  `EDPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

  // A stalled result keeps its payload
  `EDPC_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))

endmodule

bind encoder_drive_pid_controller_top edpc_checker u_edpc_checker (.*);

/* tb/encoder_drive_pid_controller_top_tb.sv */
`timescale 1ns / 1ps

module encoder_drive_pid_controller_top_tb;

  localparam int CLK_HALF_NS      = 4;
  localparam int RESET_CYCLES     = 5;
  localparam int RANDOM_ITEMS     = 1450;
  localparam int IDLE_PCT         = 19;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 40;
  localparam int TIMEOUT_NS       = 4_000_000;
  localparam int REPORT_LIMIT     = 10;

  // Turn direction codes
  localparam logic DIR_LEFT_FWD  = 1'b1;
  localparam logic DIR_RIGHT_FWD = 1'b0;

  // One drive result, fields as carried on the result stream
  typedef struct packed {
    logic [edpc_pkg::PWM_W-1:0] left_pwm;
    logic                       left_fwd;
    logic                       left_bwd;
    logic [edpc_pkg::PWM_W-1:0] right_pwm;
    logic                       right_fwd;
    logic                       right_bwd;
    logic                       done;
  } wheel_out_t;

  // One row of the directed sequence: a register write or an item
  typedef struct {
    bit                          is_reg;
    logic [edpc_pkg::IDX_W-1:0]  idx;
    logic [edpc_pkg::CFG_W-1:0]  val;
    logic                        op;
    logic                        lp;
    logic                        rp;
    bit                          known;
    wheel_out_t                  want;
  } plan_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [7:0]                   s_tdata = '0;
  logic                         s_tuser = edpc_pkg::OP_START;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [23:0]                  m_tdata;
  logic                         m_tlast;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [edpc_pkg::IDX_W-1:0]   cfg_index = '0;
  logic [edpc_pkg::CFG_W-1:0]   cfg_data = '0;

  // Register copy
  logic                         cfg_mode     = edpc_pkg::MODE_STRAIGHT;
  logic                         cfg_turn_dir = DIR_RIGHT_FWD;
  logic [edpc_pkg::TGT_W-1:0]   cfg_target   = '0;
  logic [edpc_pkg::PCT_W-1:0]   cfg_base     = edpc_pkg::RST_BASE;
  logic [edpc_pkg::PCT_W-1:0]   cfg_turn_spd = edpc_pkg::RST_TURN_SPD;
  logic [edpc_pkg::GAIN_W-1:0]  cfg_kp       = edpc_pkg::RST_GAIN_P;
  logic [edpc_pkg::GAIN_W-1:0]  cfg_ki       = edpc_pkg::RST_GAIN_I;
  logic [edpc_pkg::GAIN_W-1:0]  cfg_kd       = edpc_pkg::RST_GAIN_D;

  // Motion state copy
  logic [edpc_pkg::CNT_W-1:0]   cnt_l    = '0;
  logic [edpc_pkg::CNT_W-1:0]   cnt_r    = '0;
  longint                       err_sum  = 0;
  longint                       prev_err = 0;
  longint                       spd_r    = 0;
  logic                         moving   = 1'b0;

  wheel_out_t        expected_drive[$];
  int                mismatches = 0;
  int                items_sent = 0;
  bit                steady = 1'b0;
  bit                sink_hold_req = 1'b0;
  bit                sink_hold_taken = 1'b0;

  encoder_drive_pid_controller_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF_NS clk = ~clk;

  function automatic wheel_out_t stopped(input logic d);
    wheel_out_t r;
    r      = '0;
    r.done = d;
    return r;
  endfunction

  function automatic wheel_out_t wheels(input int lpwm, input int lf, input int lb,
                                        input int rpwm, input int rf, input int rb);
    wheel_out_t r;
    r = '{edpc_pkg::PWM_W'(lpwm), 1'(lf), 1'(lb),
          edpc_pkg::PWM_W'(rpwm), 1'(rf), 1'(rb), 1'b0};
    return r;
  endfunction

  function automatic string drive_text(input wheel_out_t w);
    return $sformatf("L pwm %0d f%0b b%0b, R pwm %0d f%0b b%0b, done %0b",
                     w.left_pwm, w.left_fwd, w.left_bwd,
                     w.right_pwm, w.right_fwd, w.right_bwd, w.done);
  endfunction

  function automatic longint sat32(input longint v);
    if (v > longint'(32'sh7fff_ffff)) return longint'(32'sh7fff_ffff);
    if (v < -longint'(33'sh0_8000_0000)) return -longint'(33'sh0_8000_0000);
    return v;
  endfunction

  function automatic bit target_hit();
    return (edpc_pkg::CMP_W'(cnt_l) >= edpc_pkg::CMP_W'(cfg_target)) ||
           (edpc_pkg::CMP_W'(cnt_r) >= edpc_pkg::CMP_W'(cfg_target));
  endfunction

  // Signed Q16.16 percent to direction bits and clamped, linearly mapped duty
  function automatic void speed_to_drive(input longint spd,
                                         output logic [edpc_pkg::PWM_W-1:0] pwm,
                                         output logic fwd, output logic bwd);
    longint mag;
    mag = ((spd < 0) ? -spd : spd) >>> edpc_pkg::FRAC_W;
    if (mag > edpc_pkg::PCT_MAX) mag = edpc_pkg::PCT_MAX;
    pwm = edpc_pkg::PWM_W'(edpc_pkg::PWM_LOW +
                           mag * (edpc_pkg::PWM_HIGH - edpc_pkg::PWM_LOW) / edpc_pkg::PCT_MAX);
    fwd = (spd >= 0);
    bwd = (spd < 0);
  endfunction

  // Advance the motion state by one item and return the drive it produces
  function automatic wheel_out_t drive_predict(input logic op, input logic lp,
                                               input logic rp);
    wheel_out_t r;
    longint     err;
    longint     pid;
    longint     ls;
    longint     rs;
    r = '0;
    if (op == edpc_pkg::OP_START) begin
      cnt_l    = '0;
      cnt_r    = '0;
      err_sum  = 0;
      prev_err = 0;
      spd_r    = longint'(cfg_base) <<< edpc_pkg::FRAC_W;
      if (target_hit()) begin
        moving = 1'b0;
        return stopped(1'b1);
      end
      moving = 1'b1;
    end else begin
      if (!moving) return r;
      if (lp && cnt_l != '1) cnt_l = cnt_l + 1'b1;
      if (rp && cnt_r != '1) cnt_r = cnt_r + 1'b1;
      if (target_hit()) begin
        moving = 1'b0;
        return stopped(1'b1);
      end
      // PID on the count difference, turn mode leaves it alone
      if (cfg_mode == edpc_pkg::MODE_STRAIGHT) begin
        err      = longint'(cnt_r) - longint'(cnt_l);
        err_sum  = sat32(err_sum + err);
        pid      = longint'(cfg_kp) * err + longint'(cfg_ki) * err_sum
                 + longint'(cfg_kd) * (err - prev_err);
        prev_err = err;
        spd_r    = sat32((longint'(cfg_base) <<< edpc_pkg::FRAC_W) - pid);
      end
    end
    if (cfg_mode == edpc_pkg::MODE_TURN) begin
      ls = longint'(cfg_turn_spd) <<< edpc_pkg::FRAC_W;
      if (cfg_turn_dir == DIR_RIGHT_FWD) ls = -ls;
      rs = -ls;
    end else begin
      ls = longint'(cfg_base) <<< edpc_pkg::FRAC_W;
      rs = spd_r;
    end
    speed_to_drive(ls, r.left_pwm, r.left_fwd, r.left_bwd);
    speed_to_drive(rs, r.right_pwm, r.right_fwd, r.right_bwd);
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [edpc_pkg::IDX_W-1:0] idx,
                                        input int val);
    plan_row_t p;
    p        = '{default: '0};
    p.is_reg = 1'b1;
    p.idx    = idx;
    p.val    = edpc_pkg::CFG_W'(val);
    return p;
  endfunction

  function automatic plan_row_t item_row(input logic op, input logic lp, input logic rp);
    plan_row_t p;
    p    = '{default: '0};
    p.op = op;
    p.lp = lp;
    p.rp = rp;
    return p;
  endfunction

  function automatic plan_row_t known_row(input logic op, input logic lp, input logic rp,
                                          input wheel_out_t want);
    plan_row_t p;
    p       = item_row(op, lp, rp);
    p.known = 1'b1;
    p.want  = want;
    return p;
  endfunction

  // Offer one item, sometimes after a random gap, and log its expected drive on acceptance
  task automatic send_item(input logic op, input logic lp, input logic rp,
                           input bit known, input wheel_out_t want);
    wheel_out_t pred;
    int         gap;
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, rp, lp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = drive_predict(op, lp, rp);
    expected_drive.push_back(known ? want : pred);
    items_sent++;
  endtask

  // Hold the input and wait until every expected result has arrived
  task automatic settle_block();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [edpc_pkg::IDX_W-1:0] idx,
                           input logic [edpc_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      edpc_pkg::REG_MODE:     cfg_mode     = val[0];
      edpc_pkg::REG_TURN_DIR: cfg_turn_dir = val[0];
      edpc_pkg::REG_TARGET:   cfg_target   = val[edpc_pkg::TGT_W-1:0];
      edpc_pkg::REG_BASE:     cfg_base     = val[edpc_pkg::PCT_W-1:0];
      edpc_pkg::REG_TURN_SPD: cfg_turn_spd = val[edpc_pkg::PCT_W-1:0];
      edpc_pkg::REG_GAIN_P:   cfg_kp       = val[edpc_pkg::GAIN_W-1:0];
      edpc_pkg::REG_GAIN_I:   cfg_ki       = val[edpc_pkg::GAIN_W-1:0];
      edpc_pkg::REG_GAIN_D:   cfg_kd       = val[edpc_pkg::GAIN_W-1:0];
      default:                ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Rewrite the target and a random subset of the other registers, or every register
  task automatic reconfigure(input bit every_reg);
    logic [edpc_pkg::CFG_W-1:0] val;
    int                         roll;
    settle_block();
    for (int i = 0; i < 8; i++) begin
      if (every_reg || edpc_pkg::IDX_W'(i) == edpc_pkg::REG_TARGET ||
          $urandom_range(1) == 1) begin
        case (edpc_pkg::IDX_W'(i))
          edpc_pkg::REG_MODE, edpc_pkg::REG_TURN_DIR: begin
            val = edpc_pkg::CFG_W'($urandom_range(1));
          end
          edpc_pkg::REG_TARGET: begin
            roll = $urandom_range(99);
            if (roll < 8) begin
              val = '0;
            end else if (roll < 78) begin
              val = edpc_pkg::CFG_W'($urandom_range(1, 24));
            end else if (roll < 93) begin
              val = edpc_pkg::CFG_W'($urandom_range(25, 80));
            end else begin
              val = edpc_pkg::CFG_W'($urandom & 32'h0000_ffff);
            end
          end
          edpc_pkg::REG_BASE, edpc_pkg::REG_TURN_SPD: begin
            case ($urandom_range(4))
              0:       val = '0;
              1:       val = edpc_pkg::CFG_W'(edpc_pkg::PCT_MAX);
              2:       val = edpc_pkg::CFG_W'(127);
              default: val = edpc_pkg::CFG_W'($urandom_range(0, 127));
            endcase
          end
          default: begin
            case ($urandom_range(5))
              0:       val = '0;
              1:       val = '1;
              2:       val = edpc_pkg::CFG_W'($urandom_range(0, 1 << 20));
              3:       val = edpc_pkg::CFG_W'($urandom_range(0, 1 << 12));
              default: val = edpc_pkg::CFG_W'($urandom);
            endcase
          end
        endcase
        cfg_write(edpc_pkg::IDX_W'(i), val);
      end
    end
  endtask

  // Result side: random stalls, one long hold on request
  initial begin : sink_ready
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req && !sink_hold_taken) begin
        sink_hold_taken = 1'b1;
        m_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each result transaction with the oldest expected drive
  always @(posedge clk) begin : result_check
    wheel_out_t got;
    wheel_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[7:0], m_tdata[8], m_tdata[9],
              m_tdata[17:10], m_tdata[18], m_tdata[19], m_tlast};
      if (expected_drive.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with nothing expected: %s", $realtime, drive_text(got));
      end else begin
        want = expected_drive.pop_front();
        if (got.left_pwm !== want.left_pwm || got.left_fwd !== want.left_fwd ||
            got.left_bwd !== want.left_bwd || got.right_pwm !== want.right_pwm ||
            got.right_fwd !== want.right_fwd || got.right_bwd !== want.right_bwd ||
            got.done !== want.done) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: mismatch\n  expected %s\n  actual   %s",
                     $realtime, drive_text(want), drive_text(got));
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan[$];
    int        first_random;
    int        motion_no;
    int        pl;
    int        pr;
    int        tick_cap;
    int        n;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Idle tick after reset, then zero target stopping at the start
    plan.push_back(known_row(edpc_pkg::OP_TICK, 1'b1, 1'b1, stopped(1'b0)));
    plan.push_back(known_row(edpc_pkg::OP_START, 1'b0, 1'b0, stopped(1'b1)));
    // Short straight motion at reset speeds and gains
    plan.push_back(reg_row(edpc_pkg::REG_TARGET, 3));
    plan.push_back(known_row(edpc_pkg::OP_START, 1'b0, 1'b0, wheels(229, 1, 0, 229, 1, 0)));
    plan.push_back(item_row(edpc_pkg::OP_TICK, 1'b1, 1'b0));
    plan.push_back(item_row(edpc_pkg::OP_TICK, 1'b0, 1'b1));
    plan.push_back(item_row(edpc_pkg::OP_TICK, 1'b1, 1'b1));
    plan.push_back(known_row(edpc_pkg::OP_TICK, 1'b1, 1'b0, stopped(1'b1)));
    plan.push_back(known_row(edpc_pkg::OP_TICK, 1'b1, 1'b1, stopped(1'b0)));
    // Turn in place at zero, full and above-full speed, both directions
    plan.push_back(reg_row(edpc_pkg::REG_MODE, edpc_pkg::MODE_TURN));
    plan.push_back(reg_row(edpc_pkg::REG_TURN_DIR, DIR_LEFT_FWD));
    plan.push_back(reg_row(edpc_pkg::REG_TURN_SPD, 0));
    plan.push_back(reg_row(edpc_pkg::REG_TARGET, 16'hffff));
    plan.push_back(known_row(edpc_pkg::OP_START, 1'b0, 1'b0, wheels(0, 1, 0, 0, 1, 0)));
    plan.push_back(known_row(edpc_pkg::OP_TICK, 1'b1, 1'b1, wheels(0, 1, 0, 0, 1, 0)));
    plan.push_back(reg_row(edpc_pkg::REG_TURN_SPD, edpc_pkg::PCT_MAX));
    plan.push_back(reg_row(edpc_pkg::REG_TURN_DIR, DIR_RIGHT_FWD));
    plan.push_back(known_row(edpc_pkg::OP_START, 1'b0, 1'b0, wheels(255, 0, 1, 255, 1, 0)));
    plan.push_back(known_row(edpc_pkg::OP_TICK, 1'b0, 1'b1, wheels(255, 0, 1, 255, 1, 0)));
    plan.push_back(reg_row(edpc_pkg::REG_TURN_DIR, DIR_LEFT_FWD));
    plan.push_back(reg_row(edpc_pkg::REG_TURN_SPD, 127));
    plan.push_back(known_row(edpc_pkg::OP_START, 1'b0, 1'b0, wheels(255, 1, 0, 255, 0, 1)));
    // Straight with maximum gains: right wheel duty clamps at full scale both ways
    plan.push_back(reg_row(edpc_pkg::REG_MODE, edpc_pkg::MODE_STRAIGHT));
    plan.push_back(reg_row(edpc_pkg::REG_BASE, 127));
    plan.push_back(reg_row(edpc_pkg::REG_GAIN_P, '1));
    plan.push_back(reg_row(edpc_pkg::REG_GAIN_I, '1));
    plan.push_back(reg_row(edpc_pkg::REG_GAIN_D, '1));
    plan.push_back(reg_row(edpc_pkg::REG_TARGET, 50));
    plan.push_back(known_row(edpc_pkg::OP_START, 1'b0, 1'b0, wheels(255, 1, 0, 255, 1, 0)));
    plan.push_back(item_row(edpc_pkg::OP_TICK, 1'b1, 1'b0));
    plan.push_back(item_row(edpc_pkg::OP_TICK, 1'b0, 1'b1));
    plan.push_back(item_row(edpc_pkg::OP_TICK, 1'b0, 1'b1));
    plan.push_back(item_row(edpc_pkg::OP_TICK, 1'b0, 1'b1));
    // Zero base speed and zero gains
    plan.push_back(reg_row(edpc_pkg::REG_BASE, 0));
    plan.push_back(reg_row(edpc_pkg::REG_GAIN_P, 0));
    plan.push_back(reg_row(edpc_pkg::REG_GAIN_I, 0));
    plan.push_back(reg_row(edpc_pkg::REG_GAIN_D, 0));
    plan.push_back(known_row(edpc_pkg::OP_START, 1'b0, 1'b0, wheels(0, 1, 0, 0, 1, 0)));
    plan.push_back(item_row(edpc_pkg::OP_TICK, 1'b1, 1'b1));
    // Full base speed with all three terms active, run to the target
    plan.push_back(reg_row(edpc_pkg::REG_BASE, edpc_pkg::PCT_MAX));
    plan.push_back(reg_row(edpc_pkg::REG_GAIN_P, edpc_pkg::RST_GAIN_P));
    plan.push_back(reg_row(edpc_pkg::REG_GAIN_I, edpc_pkg::RST_GAIN_I));
    plan.push_back(reg_row(edpc_pkg::REG_GAIN_D, 24'h01_0000));
    plan.push_back(reg_row(edpc_pkg::REG_TARGET, 3));
    plan.push_back(known_row(edpc_pkg::OP_START, 1'b0, 1'b0, wheels(255, 1, 0, 255, 1, 0)));
    plan.push_back(item_row(edpc_pkg::OP_TICK, 1'b0, 1'b1));
    plan.push_back(item_row(edpc_pkg::OP_TICK, 1'b1, 1'b0));
    plan.push_back(item_row(edpc_pkg::OP_TICK, 1'b0, 1'b1));
    plan.push_back(item_row(edpc_pkg::OP_TICK, 1'b0, 1'b1));

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle_block();
        cfg_write(plan[i].idx, plan[i].val);
      end else begin
        send_item(plan[i].op, plan[i].lp, plan[i].rp, plan[i].known, plan[i].want);
      end
    end

    // Random motions: start, ticks until the target or a cap, some noise
    first_random = items_sent;
    motion_no    = 0;
    while (items_sent - first_random < RANDOM_ITEMS) begin
      motion_no++;
      if (motion_no == 1 || $urandom_range(2) == 0) reconfigure(motion_no == 1);
      steady = (motion_no >= 30 && motion_no < 45);
      if (motion_no == 12) sink_hold_req = 1'b1;
      if ($urandom_range(19) == 0) begin
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'b0, '0);
      end
      pl       = $urandom_range(100);
      pr       = $urandom_range(100);
      tick_cap = $urandom_range(5, 120);
      send_item(edpc_pkg::OP_START, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
      n = 0;
      while (moving && n < tick_cap) begin
        send_item(edpc_pkg::OP_TICK, $urandom_range(99) < pl, $urandom_range(99) < pr,
                  1'b0, '0);
        n++;
      end
      repeat ($urandom_range(0, 2))
        send_item(edpc_pkg::OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
    end
    steady = 1'b0;

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("encoder_drive_pid_controller_top_tb: done, clean");
    end else begin
      $display("encoder_drive_pid_controller_top_tb: done, errors");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #TIMEOUT_NS;
    $display("encoder_drive_pid_controller_top_tb: done, errors");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/edpc_pkg.sv
sv/edpc_pid_serial.sv
sv/encoder_drive_pid_controller_top.sv
sv/edpc_checker.sv
tb/encoder_drive_pid_controller_top_tb.sv
